>>> hdl/rtq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtq_pkg: shared definitions of the repeating timer queue
// Sizes, codes and the structures that pass between the controller and the
// row of timer cells.
// ----------------------------------------------------------------------------
package rtq_pkg;

    // Number of timer slots, one cell each, and the most timers one poll reports.
    localparam int NUM_TIMERS  = 16;
    localparam int MAX_RESULTS = 16;

    localparam int SLOT_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int HELD_W  = $clog2(NUM_TIMERS + 1);
    localparam int RES_W   = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
    localparam int NRES_W  = $clog2(MAX_RESULTS + 1);
    localparam int HELD_OUT_W = 5;
    localparam int HELD_SAT   = 31;

    // Input word kinds and result status codes.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POLL   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [HELD_W-1:0] held_t;
    typedef logic [RES_W-1:0]  res_idx_t;
    typedef logic [NRES_W-1:0] nres_t;

    // Operation applied by every cell in a cycle.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_RANK,
        OP_UPDATE,
        OP_SHIFT
    } cell_op_t;

    // Command broadcast from the controller to all cells.
    typedef struct packed {
        cell_op_t    op;
        logic [31:0] now;
        logic        token;
        logic [15:0] tag;
        logic [15:0] period;
        logic        rpt;
        logic [31:0] expire;
    } cell_cmd_t;

    // Record that travels from cell to cell around the ring.
    typedef struct packed {
        logic        flag;
        logic        alive;
        slot_t       slot;
        slot_t       rank;
        logic [31:0] expire;
        logic [15:0] tag;
    } probe_t;

    // Firing order: earlier expiry first, the lower slot on a tie.
    function automatic logic key_less(input logic [31:0] exp_a, input slot_t slot_a,
                                      input logic [31:0] exp_b, input slot_t slot_b);
        key_less = (exp_a < exp_b) || ((exp_a == exp_b) && (slot_a < slot_b));
    endfunction

endpackage
`default_nettype wire

>>> hdl/rtq_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtq_ifs: request and response channels of the repeating timer queue
// Valid/ready channels; a word moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------

// Request channel: one insert or poll word.
interface rtq_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] timer_id;
    logic [15:0] timeout_ms;
    logic        repeat_req;
    logic [31:0] now_ms;

    modport source (output valid, kind, timer_id, timeout_ms, repeat_req, now_ms,
                    input ready);
    modport sink (input valid, kind, timer_id, timeout_ms, repeat_req, now_ms,
                  output ready);
endinterface

// Response channel: one result word.
interface rtq_rsp_if;
    logic               valid;
    logic               ready;
    logic               fired;
    logic [15:0]        fired_id;
    logic               last;
    logic               status;
    logic [4:0]         timers_held;
    logic signed [31:0] min_wait_ms;

    modport source (output valid, fired, fired_id, last, status, timers_held,
                    min_wait_ms, input ready);
    modport sink (input valid, fired, fired_id, last, status, timers_held,
                  min_wait_ms, output ready);
endinterface
`default_nettype wire

>>> hdl/rtq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtq_cell: one timer slot of the chain
// Holds one timer, works out its firing rank from the records passing by,
// applies the poll update and takes an insert token when it is free.
// ----------------------------------------------------------------------------
module rtq_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rtq_pkg::slot_t     slot_idx,
    input  wire rtq_pkg::cell_cmd_t cmd,
    input  wire rtq_pkg::probe_t    prev_probe,
    output rtq_pkg::probe_t         probe,
    input  wire logic               token_in,
    output logic                    token_out
);

    logic            valid_reg, valid_next;
    logic [31:0]     expire_reg, expire_next;
    logic [15:0]     period_reg, period_next;
    logic            rpt_reg, rpt_next;
    logic [15:0]     tag_reg, tag_next;
    logic            due_reg, due_next;
    rtq_pkg::slot_t  rank_reg, rank_next;
    rtq_pkg::probe_t probe_reg, probe_next;
    logic            token_reg, token_next;

    logic            due_now;
    logic            fire;
    logic [31:0]     rearm_exp;
    logic            keep;

    // Whether this timer is due, and whether it is among the first ones to fire.
    assign due_now   = valid_reg && (expire_reg <= cmd.now);
    assign fire      = due_reg && ({{(32 - rtq_pkg::SLOT_W){1'b0}}, rank_reg}
                                   < 32'(rtq_pkg::MAX_RESULTS));
    assign rearm_exp = cmd.now + {16'd0, period_reg};
    assign keep      = valid_reg && !(fire && !rpt_reg);

    // Next-state logic for the slot, the rank counter and the travelling record.
    always_comb
    begin
        valid_next  = valid_reg;
        expire_next = expire_reg;
        period_next = period_reg;
        rpt_next    = rpt_reg;
        tag_next    = tag_reg;
        due_next    = due_reg;
        rank_next   = rank_reg;
        probe_next  = probe_reg;
        token_next  = 1'b0;

        case (cmd.op)
            rtq_pkg::OP_LOAD:
            begin
                due_next         = due_now;
                rank_next        = '0;
                probe_next.flag   = due_now;
                probe_next.alive  = valid_reg;
                probe_next.slot   = slot_idx;
                probe_next.rank   = '0;
                probe_next.expire = expire_reg;
                probe_next.tag    = tag_reg;
            end
            rtq_pkg::OP_RANK:
            begin
                probe_next = prev_probe;
                if (prev_probe.flag &&
                    rtq_pkg::key_less(prev_probe.expire, prev_probe.slot,
                                      expire_reg, slot_idx))
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            rtq_pkg::OP_UPDATE:
            begin
                due_next          = 1'b0;
                valid_next        = keep;
                probe_next.flag   = fire;
                probe_next.alive  = keep;
                probe_next.slot   = slot_idx;
                probe_next.rank   = rank_reg;
                probe_next.expire = (fire && rpt_reg) ? rearm_exp : expire_reg;
                probe_next.tag    = tag_reg;
                if (fire && rpt_reg)
                begin
                    expire_next = rearm_exp;
                end
            end
            rtq_pkg::OP_SHIFT:
            begin
                probe_next = prev_probe;
            end
            default:
            begin
                probe_next = probe_reg;
            end
        endcase

        // The insert token stops at the first free slot.
        if (token_in)
        begin
            if (!valid_reg)
            begin
                valid_next  = 1'b1;
                expire_next = cmd.expire;
                period_next = cmd.period;
                rpt_next    = cmd.rpt;
                tag_next    = cmd.tag;
            end
            else
            begin
                token_next = 1'b1;
            end
        end
    end

    // Control state of the cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            due_reg   <= 1'b0;
            token_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            due_reg   <= due_next;
            token_reg <= token_next;
        end
    end

    // Timer contents, rank and travelling record.
    always_ff @(posedge clk)
    begin
        expire_reg <= expire_next;
        period_reg <= period_next;
        rpt_reg    <= rpt_next;
        tag_reg    <= tag_next;
        rank_reg   <= rank_next;
        probe_reg  <= probe_next;
    end

    assign probe     = probe_reg;
    assign token_out = token_reg;

endmodule
`default_nettype wire

>>> hdl/rtq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtq_ctrl: sequencer of the repeating timer queue
// Takes request words, steps the cell chain through insert or poll, gathers
// the records leaving the chain and sends the result words.
// ----------------------------------------------------------------------------
module rtq_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    rtq_req_if.sink              req,
    rtq_rsp_if.source            rsp,
    output rtq_pkg::cell_cmd_t   cmd,
    input  wire rtq_pkg::probe_t exit_probe
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_LOAD,
        S_RANK,
        S_UPDATE,
        S_COLLECT,
        S_SUM,
        S_EMIT
    } state_t;

    state_t             state_reg;
    rtq_pkg::slot_t     step_reg;
    logic               kind_reg;
    logic [31:0]        now_reg;
    logic [15:0]        tag_reg;
    logic [15:0]        period_reg;
    logic               rpt_reg;
    logic [31:0]        ins_exp_reg;
    rtq_pkg::held_t     held_reg;
    logic               any_reg;
    logic [31:0]        min_exp_reg;
    logic               status_reg;
    rtq_pkg::nres_t     nfired_reg;
    rtq_pkg::nres_t     emit_idx_reg;
    logic signed [31:0] wait_reg;

    logic               rsp_valid_reg;
    logic               rsp_fired_reg;
    logic [15:0]        rsp_id_reg;
    logic               rsp_last_reg;
    logic               rsp_status_reg;
    logic [4:0]         rsp_held_reg;
    logic signed [31:0] rsp_wait_reg;

    logic [15:0]        res_buf [rtq_pkg::MAX_RESULTS];

    logic               step_end;
    logic [33:0]        diff;
    logic [31:0]        wait_sat;
    logic [4:0]         held_sat;
    logic               emit_fired;
    logic               emit_last;

    // End of a walk over every cell.
    assign step_end = (step_reg == rtq_pkg::slot_t'(rtq_pkg::NUM_TIMERS - 1));

    // Wait until the earliest expiry, saturated to the signed 32-bit range.
    assign diff = {2'b00, min_exp_reg} - {2'b00, now_reg} - 34'd1;
    always_comb
    begin
        if (!diff[33] && (diff[32:31] != 2'b00))
        begin
            wait_sat = 32'h7FFF_FFFF;
        end
        else if (diff[33] && (diff[32:31] != 2'b11))
        begin
            wait_sat = 32'h8000_0000;
        end
        else
        begin
            wait_sat = diff[31:0];
        end
    end

    assign held_sat = (32'(held_reg) > rtq_pkg::HELD_SAT) ? 5'(rtq_pkg::HELD_SAT)
                                                           : 5'(held_reg);

    // Contents of the next result word.
    assign emit_fired = (kind_reg == rtq_pkg::KIND_POLL) && (nfired_reg != '0);
    assign emit_last  = (kind_reg == rtq_pkg::KIND_INSERT) || (nfired_reg == '0) ||
                        (emit_idx_reg == (nfired_reg - 1'b1));

    // Command to the cells.
    always_comb
    begin
        cmd.now    = now_reg;
        cmd.token  = (state_reg == S_INS) && (step_reg == '0);
        cmd.tag    = tag_reg;
        cmd.period = period_reg;
        cmd.rpt    = rpt_reg;
        cmd.expire = ins_exp_reg;
        case (state_reg)
            S_LOAD:    cmd.op = rtq_pkg::OP_LOAD;
            S_RANK:    cmd.op = rtq_pkg::OP_RANK;
            S_UPDATE:  cmd.op = rtq_pkg::OP_UPDATE;
            S_COLLECT: cmd.op = rtq_pkg::OP_SHIFT;
            default:   cmd.op = rtq_pkg::OP_HOLD;
        endcase
    end

    // Fired tags land in the result buffer at their rank.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_COLLECT) && exit_probe.flag)
        begin
            res_buf[rtq_pkg::res_idx_t'(exit_probe.rank)] <= exit_probe.tag;
        end
    end

    // Sequencer, totals and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            kind_reg       <= rtq_pkg::KIND_INSERT;
            now_reg        <= '0;
            tag_reg        <= '0;
            period_reg     <= '0;
            rpt_reg        <= 1'b0;
            ins_exp_reg    <= '0;
            held_reg       <= '0;
            any_reg        <= 1'b0;
            min_exp_reg    <= '0;
            status_reg     <= rtq_pkg::STATUS_OK;
            nfired_reg     <= '0;
            emit_idx_reg   <= '0;
            wait_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_fired_reg  <= 1'b0;
            rsp_id_reg     <= '0;
            rsp_last_reg   <= 1'b0;
            rsp_status_reg <= rtq_pkg::STATUS_OK;
            rsp_held_reg   <= '0;
            rsp_wait_reg   <= '0;
        end
        else
        begin
            // A taken word frees the output register; the emit state refills it.
            if (rsp.ready && (state_reg != S_EMIT))
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        kind_reg   <= req.kind;
                        now_reg    <= req.now_ms;
                        tag_reg    <= req.timer_id;
                        period_reg <= req.timeout_ms;
                        rpt_reg    <= req.repeat_req;
                        status_reg <= rtq_pkg::STATUS_OK;
                        step_reg   <= '0;
                        if (req.kind == rtq_pkg::KIND_POLL)
                        begin
                            state_reg <= S_LOAD;
                        end
                        else if (held_reg == rtq_pkg::held_t'(rtq_pkg::NUM_TIMERS))
                        begin
                            status_reg <= rtq_pkg::STATUS_FULL;
                            state_reg  <= S_SUM;
                        end
                        else
                        begin
                            ins_exp_reg <= req.now_ms + {16'd0, req.timeout_ms};
                            held_reg    <= held_reg + 1'b1;
                            state_reg   <= S_INS;
                        end
                    end
                end
                S_INS:
                begin
                    // The token walks the chain while the earliest expiry is updated.
                    if (step_reg == '0)
                    begin
                        any_reg <= 1'b1;
                        if (!any_reg || (ins_exp_reg < min_exp_reg))
                        begin
                            min_exp_reg <= ins_exp_reg;
                        end
                    end
                    if (step_end)
                    begin
                        state_reg <= S_SUM;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_LOAD:
                begin
                    step_reg  <= '0;
                    state_reg <= S_RANK;
                end
                S_RANK:
                begin
                    if (step_reg == rtq_pkg::slot_t'(rtq_pkg::NUM_TIMERS - 2))
                    begin
                        state_reg <= S_UPDATE;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_UPDATE:
                begin
                    nfired_reg <= '0;
                    held_reg   <= '0;
                    any_reg    <= 1'b0;
                    step_reg   <= '0;
                    state_reg  <= S_COLLECT;
                end
                S_COLLECT:
                begin
                    // One updated slot record leaves the chain each cycle.
                    if (exit_probe.flag)
                    begin
                        nfired_reg <= nfired_reg + 1'b1;
                    end
                    if (exit_probe.alive)
                    begin
                        held_reg <= held_reg + 1'b1;
                        any_reg  <= 1'b1;
                        if (!any_reg || (exit_probe.expire < min_exp_reg))
                        begin
                            min_exp_reg <= exit_probe.expire;
                        end
                    end
                    if (step_end)
                    begin
                        state_reg <= S_SUM;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_SUM:
                begin
                    wait_reg     <= any_reg ? signed'(wait_sat) : 32'sd0;
                    emit_idx_reg <= '0;
                    state_reg    <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_fired_reg  <= emit_fired;
                        rsp_id_reg     <= emit_fired ?
                                          res_buf[emit_idx_reg[rtq_pkg::RES_W-1:0]] : 16'd0;
                        rsp_last_reg   <= emit_last;
                        rsp_status_reg <= status_reg;
                        rsp_held_reg   <= held_sat;
                        rsp_wait_reg   <= wait_reg;
                        if (emit_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            emit_idx_reg <= emit_idx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.fired       = rsp_fired_reg;
    assign rsp.fired_id    = rsp_id_reg;
    assign rsp.last        = rsp_last_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.timers_held = rsp_held_reg;
    assign rsp.min_wait_ms = rsp_wait_reg;

endmodule
`default_nettype wire

>>> hdl/repeating_timer_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// repeating_timer_queue: store of repeating and one-shot software timers
// A row of timer cells joined in a ring, driven by one sequencer.
// ----------------------------------------------------------------------------
// Usage:
// - req carries one word per item: an insert (kind 0) or a poll (kind 1),
//   both stamped with the current time now_ms.
// - rsp returns the result words of that item, the final one marked by last.
//   An insert gives one word, status 1 if every slot was full. A poll gives
//   one word per expired timer, earliest first, or a single empty word.
// - Every word carries the timer count and the wait to the earliest expiry
//   as they stand after the item.
// - Sequence: an insert reaches its result once the insert token has
//   walked the cell chain one cell a cycle; a dropped insert skips the
//   walk. A poll makes one ring pass to rank the due timers and one to
//   bring the updated slots out before its first word, then gives one
//   word a cycle while the receiver takes them.
// - One item is in work at a time; req is ready again once the last word
//   sits in the output register, and the next item runs while it waits.
// - A stalled receiver holds rsp; the block waits with its next word.
// - Reset empties every slot and clears the count; timer contents are
//   written by an insert, and a poll rearms the expiry of a fired repeat.
// ----------------------------------------------------------------------------
module repeating_timer_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    rtq_req_if.sink   req,
    rtq_rsp_if.source rsp
);

    rtq_pkg::cell_cmd_t              cmd_w;
    rtq_pkg::probe_t                 probe_w [rtq_pkg::NUM_TIMERS];
    logic [rtq_pkg::NUM_TIMERS-1:0]  token_w;

    // Sequencer.
    rtq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cmd        (cmd_w),
        .exit_probe (probe_w[rtq_pkg::NUM_TIMERS-1])
    );

    // Ring of timer cells; cell 0 takes the insert token from the sequencer.
    for (genvar i = 0; i < rtq_pkg::NUM_TIMERS; i++)
    begin : g_cell
        logic token_in_w;
        if (i == 0)
        begin : g_head
            assign token_in_w = cmd_w.token;
        end
        else
        begin : g_body
            assign token_in_w = token_w[i-1];
        end

        rtq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .slot_idx   (rtq_pkg::slot_t'(i)),
            .cmd        (cmd_w),
            .prev_probe (probe_w[(i + rtq_pkg::NUM_TIMERS - 1) % rtq_pkg::NUM_TIMERS]),
            .probe      (probe_w[i]),
            .token_in   (token_in_w),
            .token_out  (token_w[i])
        );
    end

endmodule
`default_nettype wire

>>> hdl/rtq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtq_checker: port checks of the repeating timer queue
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module rtq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic        rsp_fired,
    input wire logic [15:0] rsp_fired_id,
    input wire logic        rsp_last,
    input wire logic        rsp_status,
    input wire logic [4:0]  rsp_timers_held,
    input wire logic [31:0] rsp_min_wait_ms
);

    // A response word stays offered until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response word withdrawn before it was taken");

    // A stalled response word keeps its contents.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable({rsp_fired, rsp_fired_id, rsp_last,
                                             rsp_status, rsp_timers_held,
                                             rsp_min_wait_ms}))
        else $error("stalled response word changed");

    // A word without a fired timer carries no tag and closes its item.
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_fired |-> (rsp_fired_id == 16'd0) && rsp_last)
        else $error("empty result word with a tag or not final");

    // A dropped insert reports no timer and is the only word of its item.
    a_drop_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status |-> !rsp_fired && rsp_last)
        else $error("dropped insert reported with a fired timer");

    // No new request is taken while words of a poll are still to come.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> !req_ready)
        else $error("request taken before the poll finished");

endmodule

bind repeating_timer_queue rtq_checker u_rtq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_fired       (rsp.fired),
    .rsp_fired_id    (rsp.fired_id),
    .rsp_last        (rsp.last),
    .rsp_status      (rsp.status),
    .rsp_timers_held (rsp.timers_held),
    .rsp_min_wait_ms (rsp.min_wait_ms)
);
`default_nettype wire

>>> tb/repeating_timer_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeating_timer_queue_tb: self-checking bench for the repeating timer queue
// Drives insert and poll words over the request channel, directed and then in
// random bursts, predicts every result word from an internal copy of the timer
// slots and checks the response channel field by field while it stalls at random.
// ----------------------------------------------------------------------------
module repeating_timer_queue_tb;

    // One result word as the response channel carries it.
    typedef struct packed {
        logic        fired;
        logic [15:0] fired_id;
        logic        last;
        logic        status;
        logic [4:0]  timers_held;
        logic [31:0] min_wait_ms;
    } timer_report_t;

    // Tracks the timer slots and the result words still owed by the block.
    class timer_expiry_board;
        bit            slot_busy [rtq_pkg::NUM_TIMERS];
        logic [31:0]   slot_expiry [rtq_pkg::NUM_TIMERS];
        logic [15:0]   slot_period [rtq_pkg::NUM_TIMERS];
        bit            slot_rearm [rtq_pkg::NUM_TIMERS];
        logic [15:0]   slot_tag [rtq_pkg::NUM_TIMERS];
        timer_report_t awaited_reports [$];
        int            mismatches;
        int            words_checked;
        int            inserts;
        int            drops;
        int            polls;
        int            fires;

        function int held_count();
            int n;
            n = 0;
            for (int i = 0; i < rtq_pkg::NUM_TIMERS; i++)
                if (slot_busy[i])
                    n++;
            return (n > rtq_pkg::HELD_SAT) ? rtq_pkg::HELD_SAT : n;
        endfunction

        function int rearm_count();
            int n;
            n = 0;
            for (int i = 0; i < rtq_pkg::NUM_TIMERS; i++)
                if (slot_busy[i] && slot_rearm[i])
                    n++;
            return n;
        endfunction

        // Wait to the earliest expiry, clamped to the signed 32-bit range.
        function logic [31:0] earliest_wait(logic [31:0] now);
            bit          any;
            logic [31:0] best;
            longint      d;
            any  = 0;
            best = '0;
            for (int i = 0; i < rtq_pkg::NUM_TIMERS; i++)
            begin
                if (slot_busy[i] && (!any || slot_expiry[i] < best))
                begin
                    best = slot_expiry[i];
                    any  = 1;
                end
            end
            if (!any)
                return '0;
            d = longint'(best) - longint'(now) - 1;
            if (d > 64'sd2147483647)
                d = 64'sd2147483647;
            if (d < -64'sd2147483648)
                d = -64'sd2147483648;
            return d[31:0];
        endfunction

        // Works out the result words of one accepted word and queues them.
        function void note_word(logic kind, logic [15:0] id, logic [15:0] timeout,
                                logic rpt, logic [31:0] now);
            timer_report_t item_words [$];
            timer_report_t w;
            bit            done [rtq_pkg::NUM_TIMERS];
            int            slot;
            int            sel;
            logic [4:0]    held;
            logic [31:0]   wait_ms;
            done = '{default: 1'b0};
            if (kind == rtq_pkg::KIND_INSERT)
            begin
                inserts++;
                slot = -1;
                for (int i = 0; i < rtq_pkg::NUM_TIMERS; i++)
                begin
                    if (!slot_busy[i] && slot < 0)
                        slot = i;
                end
                if (slot >= 0)
                begin
                    slot_busy[slot]   = 1;
                    slot_tag[slot]    = id;
                    slot_period[slot] = timeout;
                    slot_rearm[slot]  = rpt;
                    slot_expiry[slot] = now + {16'h0, timeout};
                end
                else
                    drops++;
                w = '{fired: 1'b0, fired_id: 16'h0, last: 1'b1,
                      status: (slot < 0) ? rtq_pkg::STATUS_FULL : rtq_pkg::STATUS_OK,
                      timers_held: 5'd0, min_wait_ms: 32'd0};
                item_words = {item_words, w};
            end
            else
            begin
                polls++;
                // Pick due timers one by one, earliest first, lower slot on a tie.
                while (item_words.size() < rtq_pkg::MAX_RESULTS)
                begin
                    sel = -1;
                    for (int i = 0; i < rtq_pkg::NUM_TIMERS; i++)
                    begin
                        if (slot_busy[i] && !done[i] && slot_expiry[i] <= now &&
                            (sel < 0 || slot_expiry[i] < slot_expiry[sel]))
                            sel = i;
                    end
                    if (sel < 0)
                        break;
                    done[sel] = 1;
                    fires++;
                    w = '{fired: 1'b1, fired_id: slot_tag[sel], last: 1'b0,
                          status: rtq_pkg::STATUS_OK, timers_held: 5'd0,
                          min_wait_ms: 32'd0};
                    item_words = {item_words, w};
                    if (slot_rearm[sel])
                        slot_expiry[sel] = now + {16'h0, slot_period[sel]};
                    else
                        slot_busy[sel] = 0;
                end
                if (item_words.size() == 0)
                begin
                    w = '{fired: 1'b0, fired_id: 16'h0, last: 1'b0,
                          status: rtq_pkg::STATUS_OK, timers_held: 5'd0,
                          min_wait_ms: 32'd0};
                    item_words = {item_words, w};
                end
                item_words[item_words.size() - 1].last = 1'b1;
            end

            // Every word of the item reports the state after the whole item.
            held    = 5'(held_count());
            wait_ms = earliest_wait(now);
            foreach (item_words[k])
            begin
                item_words[k].timers_held = held;
                item_words[k].min_wait_ms = wait_ms;
                awaited_reports = {awaited_reports, item_words[k]};
            end
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("ERROR @%0t ns: %s", $time, msg);
        endtask

        // Compares a result word with the oldest one still owed.
        task check_word(timer_report_t got);
            timer_report_t want;
            if (awaited_reports.size() == 0)
            begin
                report($sformatf("result word with none owed: fired %0d id %h last %0d",
                                 got.fired, got.fired_id, got.last));
                return;
            end
            want = awaited_reports.pop_front();
            words_checked++;
            if (got.fired !== want.fired || got.fired_id !== want.fired_id ||
                got.last !== want.last || got.status !== want.status ||
                got.timers_held !== want.timers_held ||
                got.min_wait_ms !== want.min_wait_ms)
                report($sformatf({"word %0d: got fired %0d id %h last %0d st %0d held %0d",
                                  " wait %0d, want fired %0d id %h last %0d st %0d",
                                  " held %0d wait %0d"},
                                 words_checked, got.fired, got.fired_id, got.last,
                                 got.status, got.timers_held, $signed(got.min_wait_ms),
                                 want.fired, want.fired_id, want.last, want.status,
                                 want.timers_held, $signed(want.min_wait_ms)));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    rtq_req_if         req ();
    rtq_rsp_if         rsp ();
    timer_expiry_board timer_board;
    timer_report_t     seen_word;
    logic [31:0]       clock_ms;
    int                words_sent;

    repeating_timer_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("Timeout with %0d result words still owed",
                 timer_board.awaited_reports.size());
        $display("FAIL");
        $finish;
    end

    // Receiver: switches at random between stall patterns.
    initial
    begin
        int mode;
        int phase;
        rsp.ready = 1'b0;
        mode      = 0;
        phase     = 0;
        forever
        begin
            @(negedge clk);
            if (phase == 0)
            begin
                mode  = $urandom_range(0, 3);
                phase = $urandom_range(20, 150);
            end
            phase--;
            case (mode)
                0:       rsp.ready <= 1'b1;
                1:       rsp.ready <= 1'($urandom_range(0, 1));
                2:       rsp.ready <= ($urandom_range(0, 3) == 0);
                default: rsp.ready <= (phase % 3 != 0);
            endcase
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            seen_word.fired       = rsp.fired;
            seen_word.fired_id    = rsp.fired_id;
            seen_word.last        = rsp.last;
            seen_word.status      = rsp.status;
            seen_word.timers_held = rsp.timers_held;
            seen_word.min_wait_ms = rsp.min_wait_ms;
            timer_board.check_word(seen_word);
        end
    end

    // Presents one word and holds it until the block takes it.
    task automatic send_word(input logic kind, input logic [15:0] id,
                             input logic [15:0] timeout, input logic rpt,
                             input logic [31:0] now);
        @(negedge clk);
        req.valid      <= 1'b1;
        req.kind       <= kind;
        req.timer_id   <= id;
        req.timeout_ms <= timeout;
        req.repeat_req <= rpt;
        req.now_ms     <= now;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        timer_board.note_word(kind, id, timeout, rpt, now);
        words_sent++;
    endtask

    task automatic idle_cycles(input int n);
        @(negedge clk);
        req.valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Holds the sender off until every owed result word has arrived.
    task automatic drain_results();
        @(negedge clk);
        req.valid <= 1'b0;
        while (timer_board.awaited_reports.size() != 0)
            @(posedge clk);
    endtask

    // One random word at the running clock, mostly short periods.
    task automatic random_word();
        logic [15:0] timeout;
        logic        rpt;
        if ($urandom_range(0, 29) == 0)
            clock_ms = clock_ms + $urandom_range(1000, 70000);
        else
            clock_ms = clock_ms + $urandom_range(0, 30);
        if ($urandom_range(0, 9) < 6)
        begin
            timeout = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(0, 150));
            // Repeating timers never leave, so only a few are let in.
            rpt = (timer_board.rearm_count() < 8 && $urandom_range(0, 19) == 0);
            send_word(rtq_pkg::KIND_INSERT, 16'($urandom), timeout, rpt, clock_ms);
        end
        else
            send_word(rtq_pkg::KIND_POLL, 16'($urandom), 16'($urandom), 1'($urandom),
                      clock_ms);
    endtask

    // Stimulus.
    initial
    begin
        int burst;
        timer_board    = new();
        words_sent     = 0;
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.kind       = rtq_pkg::KIND_INSERT;
        req.timer_id   = '0;
        req.timeout_ms = '0;
        req.repeat_req = 1'b0;
        req.now_ms     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty poll, zero period repeat, wrapping expiry, both
        // saturations of the wait, tie order, a full queue and a full poll.
        send_word(rtq_pkg::KIND_POLL, 16'h0, 16'h0, 1'b0, 32'd0);
        send_word(rtq_pkg::KIND_INSERT, 16'hFFFF, 16'h0000, 1'b1, 32'd0);
        send_word(rtq_pkg::KIND_INSERT, 16'h0000, 16'hFFFF, 1'b0, 32'hFFFF_FFFF);
        send_word(rtq_pkg::KIND_POLL, 16'hFFFF, 16'hFFFF, 1'b1, 32'd0);
        send_word(rtq_pkg::KIND_INSERT, 16'h1234, 16'd5, 1'b0, 32'd10);
        send_word(rtq_pkg::KIND_INSERT, 16'h4321, 16'd5, 1'b0, 32'd10);
        send_word(rtq_pkg::KIND_POLL, 16'h0, 16'h0, 1'b0, 32'd20);
        repeat (14)
            send_word(rtq_pkg::KIND_INSERT, 16'($urandom), 16'($urandom_range(0, 200)),
                      1'b0, 32'd100);
        send_word(rtq_pkg::KIND_INSERT, 16'hA5A5, 16'hFFFF, 1'b1, 32'd100);
        send_word(rtq_pkg::KIND_POLL, 16'h5A5A, 16'h0, 1'b0, 32'hFFFF_FFFF);
        drain_results();
        send_word(rtq_pkg::KIND_POLL, 16'h0, 16'h0, 1'b0, 32'd0);
        drain_results();

        // Random bursts with random gaps, and a full drain now and then.
        clock_ms = $urandom_range(0, 32'h000F_FFFF);
        while (words_sent < 420)
        begin
            burst = $urandom_range(1, 8);
            repeat (burst)
                random_word();
            if (words_sent % 100 < burst)
                drain_results();
            else if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 10));
        end

        // Wind down: wait for every owed word, then for stray ones.
        drain_results();
        repeat (3 * rtq_pkg::NUM_TIMERS + 20) @(posedge clk);
        $display("Sent %0d words: %0d inserts (%0d dropped on a full queue), %0d polls",
                 words_sent, timer_board.inserts, timer_board.drops, timer_board.polls);
        $display("Checked %0d result words, %0d timer firings, %0d mismatches",
                 timer_board.words_checked, timer_board.fires, timer_board.mismatches);
        if (timer_board.mismatches == 0 && timer_board.awaited_reports.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> repeating_timer_queue.f
hdl/rtq_pkg.sv
hdl/rtq_ifs.sv
hdl/rtq_cell.sv
hdl/rtq_ctrl.sv
hdl/repeating_timer_queue.sv
hdl/rtq_checker.sv
tb/repeating_timer_queue_tb.sv
